@@ rtl/core/tia_pkg.sv @@
// Shared types and constants for the Thumb immediate ALU execute unit.
`timescale 1ns / 1ps

package tia_pkg;

  localparam int unsigned InstrW   = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned ImmW     = 8;
  localparam int unsigned SignPos  = 31;

  localparam logic [InstrW-1:0] FmtMask = 16'hE000;
  localparam logic [InstrW-1:0] FmtImm  = 16'h2000;

  typedef enum logic [1:0] {
    OP_MOV = 2'd0,
    OP_CMP = 2'd1,
    OP_ADD = 2'd2,
    OP_SUB = 2'd3
  } tia_op_e;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } tia_flags_t;

  typedef struct packed {
    logic               reg_we;
    logic [RegIdxW-1:0] idx;
    logic [DataW-1:0]   data;
    logic               flags_we;
    tia_flags_t         flags;
  } tia_wr_t;

  typedef struct packed {
    logic               is_exception;
    logic               wrote_reg;
    logic [RegIdxW-1:0] dest_index;
    logic [DataW-1:0]   alu_value;
    tia_flags_t         flags;
  } tia_result_t;

endpackage

@@ rtl/core/tia_if.sv @@
// Valid/ready channel interfaces for instruction and result beats.
`timescale 1ns / 1ps

interface tia_instr_if;
  logic                        valid;
  logic                        ready;
  logic [tia_pkg::InstrW-1:0]  instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink (input valid, input instr_word, output ready);
endinterface

interface tia_result_if;
  logic                        valid;
  logic                        ready;
  logic                        is_exception;
  logic                        wrote_reg;
  logic [tia_pkg::RegIdxW-1:0] dest_index;
  logic [tia_pkg::DataW-1:0]   alu_value;
  logic                        flag_n;
  logic                        flag_z;
  logic                        flag_c;
  logic                        flag_v;

  modport source (
    output valid, output is_exception, output wrote_reg, output dest_index,
    output alu_value, output flag_n, output flag_z, output flag_c, output flag_v,
    input ready
  );
  modport sink (
    input valid, input is_exception, input wrote_reg, input dest_index,
    input alu_value, input flag_n, input flag_z, input flag_c, input flag_v,
    output ready
  );
endinterface

@@ rtl/core/tia_regfile.sv @@
// Eight low registers and the NZCV flags, one read port and one write port.
`timescale 1ns / 1ps

module tia_regfile (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tia_pkg::RegIdxW-1:0]   rd_idx_i,
  output logic [tia_pkg::DataW-1:0]     rd_data_o,
  output tia_pkg::tia_flags_t           flags_o,
  input  tia_pkg::tia_wr_t              wr_i
);
  import tia_pkg::*;

  logic [DataW-1:0] regs_q [NumRegs];
  tia_flags_t       flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        regs_q[i] <= '0;
      end
      flags_q <= '0;
    end else begin
      if (wr_i.reg_we) begin
        regs_q[wr_i.idx] <= wr_i.data;
      end
      if (wr_i.flags_we) begin
        flags_q <= wr_i.flags;
      end
    end
  end

  assign rd_data_o = regs_q[rd_idx_i];
  assign flags_o   = flags_q;

endmodule

@@ rtl/core/tia_alu.sv @@
// Decode of the immediate ALU format, shared add/subtract and flag logic.
`timescale 1ns / 1ps

module tia_alu (
  input  logic                        valid_i,
  input  logic [tia_pkg::InstrW-1:0]  instr_i,
  input  logic [tia_pkg::DataW-1:0]   rd_data_i,
  input  tia_pkg::tia_flags_t         flags_i,
  output logic [tia_pkg::RegIdxW-1:0] rd_idx_o,
  output tia_pkg::tia_result_t        result_o,
  output tia_pkg::tia_wr_t            wr_o
);
  import tia_pkg::*;

  logic             fmt_ok;
  tia_op_e          op;
  logic [DataW-1:0] imm;
  logic [DataW-1:0] b_eff;
  logic             is_sub;
  logic [DataW:0]   sum;
  logic [DataW-1:0] res;
  logic             carry;
  logic             ovf;
  tia_flags_t       flags_new;
  logic [DataW-1:0] value;
  logic             wrote;

  assign fmt_ok   = (instr_i & FmtMask) == FmtImm;
  assign op       = tia_op_e'(instr_i[12:11]);
  assign rd_idx_o = instr_i[10:8];
  assign imm      = DataW'(instr_i[ImmW-1:0]);
  assign is_sub   = (op == OP_CMP) || (op == OP_SUB);
  assign b_eff    = is_sub ? ~imm : imm;
  assign sum      = {1'b0, rd_data_i} + {1'b0, b_eff} + (DataW+1)'(is_sub);
  assign res      = sum[DataW-1:0];
  assign carry    = sum[DataW];
  assign ovf      = (rd_data_i[SignPos] == b_eff[SignPos]) &&
                    (res[SignPos] != rd_data_i[SignPos]);

  always_comb begin
    flags_new = flags_i;
    value     = res;
    wrote     = 1'b1;
    unique case (op)
      OP_MOV: begin
        value       = imm;
        flags_new.n = imm[SignPos];
        flags_new.z = (imm == '0);
      end
      OP_CMP, OP_ADD, OP_SUB: begin
        flags_new.n = res[SignPos];
        flags_new.z = (res == '0);
        flags_new.c = carry;
        flags_new.v = ovf;
        wrote       = (op != OP_CMP);
      end
      default: begin
        value = res;
      end
    endcase
  end

  always_comb begin
    result_o.is_exception = !fmt_ok;
    result_o.wrote_reg    = fmt_ok && wrote;
    result_o.dest_index   = fmt_ok ? rd_idx_o : '0;
    result_o.alu_value    = fmt_ok ? value : '0;
    result_o.flags        = fmt_ok ? flags_new : flags_i;

    wr_o.reg_we   = valid_i && fmt_ok && wrote;
    wr_o.idx      = rd_idx_o;
    wr_o.data     = value;
    wr_o.flags_we = valid_i && fmt_ok;
    wr_o.flags    = flags_new;
  end

endmodule

@@ rtl/core/thumb_alu_immediate_execute_unit.sv @@
// Top level: instruction register, execute and result register.
//
//   channel   dir  beat payload
//   instr_i   in   instr_word[15:0]
//   result_o  out  is_exception, wrote_reg, dest_index[2:0], alu_value[31:0],
//                  flag_n, flag_z, flag_c, flag_v
//
// One beat per cycle sustained while result_o is ready.
// The register file and flags update when an instruction moves into the
// result register, so the next instruction already reads the new values.
// Reset clears all eight registers, the flags and both valid bits.
// A stalled result holds; the instruction register keeps taking beats until
// both stages are full.
`timescale 1ns / 1ps

module thumb_alu_immediate_execute_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  tia_instr_if.sink    instr_i,
  tia_result_if.source result_o
);
  import tia_pkg::*;

  logic               s0_valid_q;
  logic [InstrW-1:0]  s0_instr_q;
  logic               s0_advance;
  logic               in_ready;
  logic               out_valid_q;
  tia_result_t        out_q;
  logic [RegIdxW-1:0] rd_idx;
  logic [DataW-1:0]   rd_data;
  tia_flags_t         flags;
  tia_result_t        result;
  tia_wr_t            wr;

  assign s0_advance = s0_valid_q && (!out_valid_q || result_o.ready);
  assign in_ready   = !s0_valid_q || s0_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        s0_valid_q <= instr_i.valid;
      end
      if (s0_advance) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && instr_i.valid) begin
      s0_instr_q <= instr_i.instr_word;
    end
    if (s0_advance) begin
      out_q <= result;
    end
  end

  tia_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data),
    .flags_o   (flags),
    .wr_i      (wr)
  );

  tia_alu u_alu (
    .valid_i   (s0_advance),
    .instr_i   (s0_instr_q),
    .rd_data_i (rd_data),
    .flags_i   (flags),
    .rd_idx_o  (rd_idx),
    .result_o  (result),
    .wr_o      (wr)
  );

  assign instr_i.ready         = in_ready;
  assign result_o.valid        = out_valid_q;
  assign result_o.is_exception = out_q.is_exception;
  assign result_o.wrote_reg    = out_q.wrote_reg;
  assign result_o.dest_index   = out_q.dest_index;
  assign result_o.alu_value    = out_q.alu_value;
  assign result_o.flag_n       = out_q.flags.n;
  assign result_o.flag_z       = out_q.flags.z;
  assign result_o.flag_c       = out_q.flags.c;
  assign result_o.flag_v       = out_q.flags.v;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> s0_valid_q && out_valid_q && !result_o.ready)
    else $error("instruction stage stalled with room downstream");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_advance |=> out_valid_q)
    else $error("advanced beat missing from result register");

  a_exc_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.is_exception |->
      !out_q.wrote_reg && out_q.dest_index == '0 && out_q.alu_value == '0)
    else $error("exception beat carries a register result");

  a_nz_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.is_exception |->
      out_q.flags.z == (out_q.alu_value == '0) &&
      out_q.flags.n == out_q.alu_value[SignPos])
    else $error("N or Z flag disagrees with result value");

  a_flags_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s0_advance |=> $stable(flags))
    else $error("flags changed without an executed instruction");

endmodule

@@ dv/tb_thumb_alu_immediate_execute_unit.sv @@
// Testbench for the Thumb immediate ALU execute unit: predicts and checks every result beat.
`timescale 1ns / 1ps

module tb_thumb_alu_immediate_execute_unit;
  import tia_pkg::*;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned RandomItems = 1600;

  class tia_exec_scoreboard;
    logic [DataW-1:0] low_regs [NumRegs];
    tia_flags_t       nzcv;
    tia_result_t      pending_results [$];
    int               errors;

    function new();
      foreach (low_regs[i]) low_regs[i] = '0;
      nzcv   = '0;
      errors = 0;
    endfunction

    function void note_instr(logic [InstrW-1:0] word);
      tia_result_t      res;
      tia_op_e          op;
      logic [DataW-1:0] a;
      logic [DataW-1:0] b;
      logic [DataW-1:0] value;
      logic [DataW:0]   wide;
      res = '0;
      if ((word & FmtMask) == FmtImm) begin
        op             = tia_op_e'(word[12:11]);
        res.dest_index = word[10:8];
        a              = low_regs[word[10:8]];
        b              = {{(DataW-ImmW){1'b0}}, word[ImmW-1:0]};
        case (op)
          OP_MOV: begin
            value = b;
          end
          OP_ADD: begin
            wide   = {1'b0, a} + {1'b0, b};
            value  = wide[DataW-1:0];
            nzcv.c = wide[DataW];
            nzcv.v = (a[SignPos] == b[SignPos]) && (value[SignPos] != a[SignPos]);
          end
          default: begin
            value  = a - b;
            nzcv.c = (a >= b);
            nzcv.v = (a[SignPos] != b[SignPos]) && (value[SignPos] != a[SignPos]);
          end
        endcase
        nzcv.n        = value[SignPos];
        nzcv.z        = (value == '0);
        res.alu_value = value;
        res.wrote_reg = (op != OP_CMP);
        if (op != OP_CMP) low_regs[word[10:8]] = value;
      end else begin
        res.is_exception = 1'b1;
      end
      res.flags = nzcv;
      pending_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [DataW-1:0] exp, logic [DataW-1:0] got);
      if (exp !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, got);
      end
    endfunction

    function void check_result(tia_result_t got);
      tia_result_t exp;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
        return;
      end
      exp = pending_results.pop_front();
      compare_field("is_exception", DataW'(exp.is_exception), DataW'(got.is_exception));
      compare_field("wrote_reg", DataW'(exp.wrote_reg), DataW'(got.wrote_reg));
      compare_field("dest_index", DataW'(exp.dest_index), DataW'(got.dest_index));
      compare_field("alu_value", exp.alu_value, got.alu_value);
      compare_field("flag_n", DataW'(exp.flags.n), DataW'(got.flags.n));
      compare_field("flag_z", DataW'(exp.flags.z), DataW'(got.flags.z));
      compare_field("flag_c", DataW'(exp.flags.c), DataW'(got.flags.c));
      compare_field("flag_v", DataW'(exp.flags.v), DataW'(got.flags.v));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tia_instr_if  instr_bus ();
  tia_result_if result_bus ();

  thumb_alu_immediate_execute_unit DUT (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .instr_i  (instr_bus.sink),
    .result_o (result_bus.source)
  );

  tia_exec_scoreboard exec_sb;
  int unsigned        result_beats;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int unsigned pick_gap(bit burst);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  function automatic logic [InstrW-1:0] imm_instr(tia_op_e op, int unsigned rd,
                                                  int unsigned imm);
    logic [RegIdxW-1:0] idx;
    logic [ImmW-1:0]    val;
    idx = rd[RegIdxW-1:0];
    val = imm[ImmW-1:0];
    return {3'b001, op, idx, val};
  endfunction

  function automatic logic [InstrW-1:0] random_instr();
    int unsigned roll;
    int unsigned imm;
    roll = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: imm = 0;
      1: imm = 255;
      default: imm = $urandom_range(0, 255);
    endcase
    if (roll < 82) return imm_instr(tia_op_e'($urandom_range(0, 3)), $urandom_range(0, 7), imm);
    return InstrW'($urandom_range(0, 65535));
  endfunction

  task automatic send_instr(logic [InstrW-1:0] word, bit burst);
    int unsigned gap;
    gap = pick_gap(burst);
    if (gap > 0) begin
      instr_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_bus.valid      <= 1'b1;
    instr_bus.instr_word <= word;
    do @(posedge clk); while (!instr_bus.ready);
    exec_sb.note_instr(word);
  endtask

  task automatic receive_results();
    int unsigned gap;
    tia_result_t got;
    forever begin
      gap = pick_gap((result_beats / 150) % 4 == 1);
      if (result_beats == 300 || result_beats == 1100) gap = 80;
      if (gap > 0) begin
        result_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!result_bus.valid);
      got.is_exception = result_bus.is_exception;
      got.wrote_reg    = result_bus.wrote_reg;
      got.dest_index   = result_bus.dest_index;
      got.alu_value    = result_bus.alu_value;
      got.flags.n      = result_bus.flag_n;
      got.flags.z      = result_bus.flag_z;
      got.flags.c      = result_bus.flag_c;
      got.flags.v      = result_bus.flag_v;
      exec_sb.check_result(got);
      result_beats++;
    end
  endtask

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((instr_bus.valid && instr_bus.ready) || (result_bus.valid && result_bus.ready) ||
          !rst_n) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [InstrW-1:0] directed [$];
    exec_sb      = new();
    result_beats = 0;
    rst_n                <= 1'b0;
    instr_bus.valid      <= 1'b0;
    instr_bus.instr_word <= '0;
    result_bus.ready     <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    fork
      receive_results();
    join_none

    directed = {
      imm_instr(OP_MOV, 0, 0),    imm_instr(OP_MOV, 1, 8'h80), imm_instr(OP_MOV, 7, 8'hFF),
      imm_instr(OP_CMP, 0, 0),    imm_instr(OP_SUB, 0, 1),     imm_instr(OP_CMP, 0, 8'hFF),
      imm_instr(OP_ADD, 0, 1),    imm_instr(OP_MOV, 2, 5),     16'h0000,
      16'hFFFF,                   16'hDFFF,                    16'h4000,
      imm_instr(OP_ADD, 7, 8'hFF), imm_instr(OP_SUB, 1, 8'h80), imm_instr(OP_SUB, 3, 8'hFF),
      imm_instr(OP_ADD, 3, 8'hFF), imm_instr(OP_CMP, 4, 1),     imm_instr(OP_ADD, 5, 0),
      imm_instr(OP_SUB, 6, 0),    imm_instr(OP_MOV, 6, 8'hAA), imm_instr(OP_ADD, 6, 8'h55),
      16'h3FFF,                   16'h1FFF
    };
    foreach (directed[i]) send_instr(directed[i], 1'b0);

    for (int unsigned i = 0; i < RandomItems; i++) begin
      send_instr(random_instr(), (i / 100) % 3 == 0);
    end
    instr_bus.valid <= 1'b0;

    while (exec_sb.pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (exec_sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ thumb_alu_immediate_execute_unit.f @@
rtl/core/tia_pkg.sv
rtl/core/tia_if.sv
rtl/core/tia_regfile.sv
rtl/core/tia_alu.sv
rtl/core/thumb_alu_immediate_execute_unit.sv
dv/tb_thumb_alu_immediate_execute_unit.sv
